@@ rtl/core/assert_macros.svh @@
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same cycle, disabled during reset.
`define VL_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Implication into the next cycle, disabled during reset.
`define VL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/vl2i_pkg.sv @@
// Package: widths, pipeline depths and lane result type for the 2D lerp block.
`default_nettype none
package vl2i_pkg;
    localparam int W          = 64;
    localparam int MUL_STAGES = 5;
    localparam int DIV_STAGES = W;
    localparam int LAT        = MUL_STAGES + DIV_STAGES;

    typedef struct packed {
        logic         neg;
        logic [W-1:0] quo;
    } t_lane_res;
endpackage
`default_nettype wire

@@ rtl/core/vl2i_wsum.sv @@
// Pipelined weighted sum start*(total-step)+end*step, returned as sign and magnitude.
`default_nettype none
module vl2i_wsum (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [vl2i_pkg::W-1:0]       i_a,
    input  logic [vl2i_pkg::W-1:0]       i_b,
    input  logic [vl2i_pkg::W-1:0]       i_cur,
    input  logic [vl2i_pkg::W-1:0]       i_tot,
    output logic                         o_neg,
    output logic [2*vl2i_pkg::W-1:0]     o_mag,
    output logic [vl2i_pkg::W-1:0]       o_tot
);
    localparam int W = vl2i_pkg::W;
    localparam int H = W / 2;

    logic [W-1:0]   r_mag_a, r_mag_b, r_w0, r_w1, r_tot_a;
    logic           r_neg_a, r_neg_b;
    logic [W-1:0]   r_pa [4];
    logic [W-1:0]   r_pb [4];
    logic           r_neg_a_b, r_neg_b_b;
    logic [W-1:0]   r_tot_b;
    logic [2*W-1:0] r_prod_a, r_prod_b;
    logic           r_neg_a_c, r_neg_b_c;
    logic [W-1:0]   r_tot_c;
    logic [2*W:0]   r_sum;
    logic [W-1:0]   r_tot_d;
    logic           r_neg;
    logic [2*W-1:0] r_mag;
    logic [W-1:0]   r_tot_e;

    logic [2*W:0]   n_sa, n_sb, n_sum_abs;

    always_comb begin
        n_sa = r_neg_a_c ? (~{1'b0, r_prod_a} + 1'b1) : {1'b0, r_prod_a};
        n_sb = r_neg_b_c ? (~{1'b0, r_prod_b} + 1'b1) : {1'b0, r_prod_b};
        n_sum_abs = r_sum[2*W] ? (~r_sum + 1'b1) : r_sum;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg_a <= i_a[W-1];
            r_neg_b <= i_b[W-1];
            r_mag_a <= i_a[W-1] ? (~i_a + 1'b1) : i_a;
            r_mag_b <= i_b[W-1] ? (~i_b + 1'b1) : i_b;
            r_w0    <= i_tot - i_cur;
            r_w1    <= i_cur;
            r_tot_a <= i_tot;

            r_pa[0] <= r_mag_a[H-1:0] * r_w0[H-1:0];
            r_pa[1] <= r_mag_a[H-1:0] * r_w0[W-1:H];
            r_pa[2] <= r_mag_a[W-1:H] * r_w0[H-1:0];
            r_pa[3] <= r_mag_a[W-1:H] * r_w0[W-1:H];
            r_pb[0] <= r_mag_b[H-1:0] * r_w1[H-1:0];
            r_pb[1] <= r_mag_b[H-1:0] * r_w1[W-1:H];
            r_pb[2] <= r_mag_b[W-1:H] * r_w1[H-1:0];
            r_pb[3] <= r_mag_b[W-1:H] * r_w1[W-1:H];
            r_neg_a_b <= r_neg_a;
            r_neg_b_b <= r_neg_b;
            r_tot_b   <= r_tot_a;

            r_prod_a <= {{W{1'b0}}, r_pa[0]} + {{H{1'b0}}, r_pa[1], {H{1'b0}}}
                      + {{H{1'b0}}, r_pa[2], {H{1'b0}}} + {r_pa[3], {W{1'b0}}};
            r_prod_b <= {{W{1'b0}}, r_pb[0]} + {{H{1'b0}}, r_pb[1], {H{1'b0}}}
                      + {{H{1'b0}}, r_pb[2], {H{1'b0}}} + {r_pb[3], {W{1'b0}}};
            r_neg_a_c <= r_neg_a_b;
            r_neg_b_c <= r_neg_b_b;
            r_tot_c   <= r_tot_b;

            r_sum   <= n_sa + n_sb;
            r_tot_d <= r_tot_c;

            r_neg   <= r_sum[2*W];
            r_mag   <= n_sum_abs[2*W-1:0];
            r_tot_e <= r_tot_d;
        end
    end

    assign o_neg = r_neg;
    assign o_mag = r_mag;
    assign o_tot = r_tot_e;
endmodule
`default_nettype wire

@@ rtl/core/vl2i_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, sign carried alongside.
`default_nettype none
module vl2i_div (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_neg,
    input  logic [2*vl2i_pkg::W-1:0] i_num,
    input  logic [vl2i_pkg::W-1:0]   i_den,
    output vl2i_pkg::t_lane_res      o_res
);
    localparam int W = vl2i_pkg::W;
    localparam int N = vl2i_pkg::DIV_STAGES;

    logic [W-1:0] r_rem [N];
    logic [W-1:0] r_lo  [N];
    logic [W-1:0] r_quo [N];
    logic [W-1:0] r_den [N];
    logic         r_neg [N];

    logic [W-1:0] n_rem [N];
    logic [W-1:0] n_lo  [N];
    logic [W-1:0] n_quo [N];
    logic [W-1:0] n_den [N];
    logic         n_neg [N];

    always_comb begin
        logic [W-1:0] rem_in, lo_in, quo_in, den_in;
        logic         neg_in;
        logic [W:0]   trial;
        logic         ge;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                rem_in = i_num[2*W-1:W];
                lo_in  = i_num[W-1:0];
                quo_in = '0;
                den_in = i_den;
                neg_in = i_neg;
            end else begin
                rem_in = r_rem[k-1];
                lo_in  = r_lo[k-1];
                quo_in = r_quo[k-1];
                den_in = r_den[k-1];
                neg_in = r_neg[k-1];
            end
            trial    = {rem_in, lo_in[W-1]};
            ge       = trial >= {1'b0, den_in};
            n_rem[k] = ge ? (trial[W-1:0] - den_in) : trial[W-1:0];
            n_lo[k]  = {lo_in[W-2:0], 1'b0};
            n_quo[k] = {quo_in[W-2:0], ge};
            n_den[k] = den_in;
            n_neg[k] = neg_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N; k++) begin
                r_rem[k] <= n_rem[k];
                r_lo[k]  <= n_lo[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= n_den[k];
                r_neg[k] <= n_neg[k];
            end
        end
    end

    assign o_res.neg = r_neg[N-1];
    assign o_res.quo = r_quo[N-1];
endmodule
`default_nettype wire

@@ rtl/core/vl2i_lane.sv @@
// One axis lane: weighted sum followed by the divider pipeline.
`default_nettype none
module vl2i_lane (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [vl2i_pkg::W-1:0] i_a,
    input  logic [vl2i_pkg::W-1:0] i_b,
    input  logic [vl2i_pkg::W-1:0] i_cur,
    input  logic [vl2i_pkg::W-1:0] i_tot,
    output vl2i_pkg::t_lane_res    o_res
);
    logic                     neg;
    logic [2*vl2i_pkg::W-1:0] mag;
    logic [vl2i_pkg::W-1:0]   tot;

    vl2i_wsum u_wsum (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_a   (i_a),
        .i_b   (i_b),
        .i_cur (i_cur),
        .i_tot (i_tot),
        .o_neg (neg),
        .o_mag (mag),
        .o_tot (tot)
    );

    vl2i_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_neg (neg),
        .i_num (mag),
        .i_den (tot),
        .o_res (o_res)
    );
endmodule
`default_nettype wire

@@ rtl/core/vector_lerp_2d_int_top.sv @@
// Top level: two axis lanes, argument check and output merge register.
//
//  channel | valid    | ready    | payload
//  --------+----------+----------+----------------------------------------------
//  input   | i_valid  | o_ready  | i_start_x/y, i_end_x/y, i_step_now, i_step_total
//  output  | o_valid  | i_ready  | o_point_x, o_point_y, o_bad_args
//
//  One item per cycle unless the output stalls; 5 multiply/sum stages, 64
//  divider stages and one output register. The divider pipeline, one quotient
//  bit per stage, sets the depth. The whole pipeline holds only while the output
//  register is full and not taken. Reset clears the valid bits only.
`default_nettype none
module vector_lerp_2d_int_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [vl2i_pkg::W-1:0] i_start_x,
    input  logic signed [vl2i_pkg::W-1:0] i_start_y,
    input  logic signed [vl2i_pkg::W-1:0] i_end_x,
    input  logic signed [vl2i_pkg::W-1:0] i_end_y,
    input  logic        [vl2i_pkg::W-1:0] i_step_now,
    input  logic        [vl2i_pkg::W-1:0] i_step_total,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [vl2i_pkg::W-1:0] o_point_x,
    output logic signed [vl2i_pkg::W-1:0] o_point_y,
    output logic                          o_bad_args
);
    localparam int W   = vl2i_pkg::W;
    localparam int LAT = vl2i_pkg::LAT;

    logic                en;
    logic                in_bad;
    vl2i_pkg::t_lane_res res_x, res_y;

    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_bad;
    logic           r_out_vld;
    logic [W-1:0]   r_px, r_py;
    logic           r_out_bad;

    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;
    assign in_bad  = (i_step_total == '0) || (i_step_now > i_step_total);

    vl2i_lane u_lane_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (i_start_x),
        .i_b   (i_end_x),
        .i_cur (i_step_now),
        .i_tot (i_step_total),
        .o_res (res_x)
    );

    vl2i_lane u_lane_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (i_start_y),
        .i_b   (i_end_y),
        .i_cur (i_step_now),
        .i_tot (i_step_total),
        .o_res (res_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[LAT-2:0], i_valid};
            r_out_vld <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bad     <= {r_bad[LAT-2:0], in_bad};
            r_out_bad <= r_bad[LAT-1];
            if (r_bad[LAT-1]) begin
                r_px <= '0;
                r_py <= '0;
            end else begin
                r_px <= res_x.neg ? (~res_x.quo + 1'b1) : res_x.quo;
                r_py <= res_y.neg ? (~res_y.quo + 1'b1) : res_y.quo;
            end
        end
    end

    assign o_valid    = r_out_vld;
    assign o_point_x  = r_px;
    assign o_point_y  = r_py;
    assign o_bad_args = r_out_bad;
endmodule
`default_nettype wire

@@ rtl/core/vl2i_checker.sv @@
// Port-level checker for the 2D lerp block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module vl2i_checker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   o_ready,
    input  logic                   o_valid,
    input  logic                   i_ready,
    input  logic [vl2i_pkg::W-1:0] o_point_x,
    input  logic [vl2i_pkg::W-1:0] o_point_y,
    input  logic                   o_bad_args
);
    `VL_ASSERT_NOW(a_bad_zero, i_clk, i_rst_n, o_valid && o_bad_args, o_point_x == '0 && o_point_y == '0, "bad arguments with nonzero point")
    `VL_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !o_ready, o_valid && !i_ready, "input stalled without a blocked result")
    `VL_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_point_x) && $stable(o_point_y) && $stable(o_bad_args), "result changed while stalled")
endmodule

bind vector_lerp_2d_int_top vl2i_checker u_vl2i_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_point_x  (o_point_x),
    .o_point_y  (o_point_y),
    .o_bad_args (o_bad_args)
);
`default_nettype wire
